FILE: rtl/sis_pkg.sv
package sis_pkg;

  typedef enum logic [1:0] {
    FUNC_EDGE  = 2'd0,
    FUNC_INIT  = 2'd1,
    FUNC_UPD   = 2'd2,
    FUNC_ENDDAY = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COUNT,
    ST_POWER,
    ST_DONE
  } state_t;

  localparam int unsigned REG_BETA = 0;
  localparam int unsigned REG_DAYS = 1;

endpackage

FILE: rtl/sis_power.sv
module sis_power #(
  parameter int PROB_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [PROB_BITS:0]   base_in,
  input  logic [6:0]           exp_in,
  output logic                 done,
  output logic [PROB_BITS:0]   result
);
  localparam logic [PROB_BITS:0] ONE = {1'b1, {PROB_BITS{1'b0}}};

  logic [PROB_BITS:0] base;
  logic [6:0]         e;
  logic               run;
  logic [2*PROB_BITS+1:0] pr;
  logic [2*PROB_BITS+1:0] pb;

  // one bit of the exponent per cycle; an operand at 1.0 passes the other through
  always_comb begin
    pr = {{(PROB_BITS+1){1'b0}}, result} * {{(PROB_BITS+1){1'b0}}, base};
    pb = {{(PROB_BITS+1){1'b0}}, base} * {{(PROB_BITS+1){1'b0}}, base};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run    <= 1'b1;
        base   <= base_in;
        e      <= exp_in;
        result <= ONE;
      end else if (run) begin
        if (e == 7'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          if (e[0]) begin
            if (result >= ONE) result <= base;
            else if (base < ONE) result <= pr[2*PROB_BITS:PROB_BITS];
          end
          if (base < ONE) base <= pb[2*PROB_BITS:PROB_BITS];
          e <= {1'b0, e[6:1]};
        end
      end
    end
  end
endmodule

FILE: rtl/network_sis_epidemic_step.sv
// Func 0, 1 and 3 pass from start through READ and DONE to the strobe; func 2
// walks the adjacency rows in COUNT for every node, one row per cycle;
// a susceptible node then also runs the power unit, one step per bit of k.
// One item at a time; busy is high meanwhile. The receiver cannot stall.
// Reset clears the day vectors and sweeps the adjacency memory, one row per
// cycle, with busy high.
module network_sis_epidemic_step #(
  parameter int NODES     = 64,
  parameter int DAY_BITS  = 8,
  parameter int PROB_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [5:0]  node,
  input  logic [5:0]  other_node,
  input  logic        bit_value,
  input  logic [7:0]  initial_days,
  input  logic [15:0] random_u,
  output logic        done,
  output logic [5:0]  out_node,
  output logic        infected,
  output logic [7:0]  days_left,
  output logic [6:0]  infected_neighbors,
  output logic [63:0] day_vector,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sis_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [DAY_BITS-1:0] DMAX = {DAY_BITS{1'b1}};
  localparam logic [PROB_BITS:0] ONE = {1'b1, {PROB_BITS{1'b0}}};

  logic [15:0] beta_q16;
  logic [7:0]  infect_days;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      beta_q16    <= 16'd6554;
      infect_days <= 8'd7;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DAYS[0]) infect_days <= pwdata[7:0];
      else beta_q16 <= pwdata[15:0];
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_DAYS[0]) prdata = {24'd0, infect_days};
    else prdata = {16'd0, beta_q16};
  end

  // effective day count
  logic [DAY_BITS-1:0] deff;
  always_comb begin
    if (infect_days == 8'd0) deff = {{(DAY_BITS-1){1'b0}}, 1'b1};
    else if ({24'd0, infect_days} > 32'(DMAX)) deff = DMAX;
    else deff = DAY_BITS'(infect_days);
  end

  function automatic logic [PROB_BITS:0] to_prob(input logic [15:0] q);
    logic [PROB_BITS+16:0] w;
    w = {{(PROB_BITS+1){1'b0}}, q} << PROB_BITS;
    return w[PROB_BITS+16:16];
  endfunction

  // memories
  logic [NODES-1:0]    adj_mem [NODES];
  logic [DAY_BITS-1:0] days_mem [NODES];
  logic [NODES-1:0]    adj_q;
  logic [DAY_BITS-1:0] days_q;
  logic                adj_we;
  logic [AW-1:0]       adj_wa, adj_ra;
  logic [NODES-1:0]    adj_wd;
  logic                days_we;
  logic [DAY_BITS-1:0] days_wd;
  logic [AW-1:0]       days_a;

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_q <= adj_mem[adj_ra];
  end
  always_ff @(posedge clk) begin
    if (days_we) days_mem[days_a] <= days_wd;
    days_q <= days_mem[days_a];
  end

  logic [NODES-1:0] prev_bits, next_bits;
  state_t state, state_next;
  logic   clearing;
  logic [AW:0] cnt;
  logic [AW:0] rd;
  logic [1:0]  f;
  logic [5:0]  n, o;
  logic        b;
  logic [7:0]  idays;
  logic [15:0] u;
  logic [6:0]  k;
  logic        pgo, pdone;
  logic [PROB_BITS:0] ppow;

  logic in_range;
  assign in_range = ({26'd0, n} < 32'(NODES)) &&
                    (f != FUNC_EDGE || {26'd0, o} < 32'(NODES));

  sis_power #(.PROB_BITS(PROB_BITS)) u_pow (
    .clk(clk), .rst(rst), .go(pgo),
    .base_in(ONE - to_prob(beta_q16)), .exp_in(k),
    .done(pdone), .result(ppow)
  );

  assign busy = clearing || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    adj_ra = AW'(rd);
    if (state == ST_IDLE) adj_ra = node[AW-1:0];
    else if (state == ST_READ) adj_ra = '0;
    days_a = n[AW-1:0];
    if (state == ST_IDLE) days_a = node[AW-1:0];
    pgo = 1'b0;
    case (state)
      ST_IDLE:  if (start && !clearing) state_next = ST_READ;
      ST_READ: begin
        if (f == FUNC_UPD && in_range) state_next = ST_COUNT;
        else state_next = ST_DONE;
      end
      ST_COUNT: if (cnt == (AW+1)'(NODES)) begin
        if (prev_bits[n[AW-1:0]]) state_next = ST_DONE;
        else begin
          state_next = ST_POWER;
          pgo = 1'b1;
        end
      end
      ST_POWER: if (pdone) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  logic [DAY_BITS-1:0] init_days;
  always_comb begin
    init_days = deff;
    if (b) begin
      if (idays == 8'd0) init_days = {{(DAY_BITS-1){1'b0}}, 1'b1};
      else if ({24'd0, idays} > {{(32-DAY_BITS){1'b0}}, deff}) init_days = deff;
      else init_days = DAY_BITS'(idays);
    end
  end

  logic               now_inf;
  logic [DAY_BITS-1:0] upd_days;
  always_comb begin
    now_inf  = to_prob(u) < (ONE - ppow);
    upd_days = days_q;
    if (prev_bits[n[AW-1:0]]) begin
      if (days_q <= {{(DAY_BITS-1){1'b0}}, 1'b1}) begin
        upd_days = deff;
        now_inf  = 1'b0;
      end else begin
        upd_days = days_q - 1'b1;
        now_inf  = 1'b1;
      end
    end
  end

  always_comb begin
    adj_we  = 1'b0;
    adj_wa  = n[AW-1:0];
    adj_wd  = adj_q;
    days_we = 1'b0;
    days_wd = init_days;
    if (clearing) begin
      adj_we = 1'b1;
      adj_wa = AW'(cnt);
      adj_wd = '0;
    end else if (state == ST_READ && in_range && f == FUNC_EDGE) begin
      adj_we = 1'b1;
      adj_wd[o[AW-1:0]] = b;
    end else if (state == ST_READ && in_range && f == FUNC_INIT) begin
      days_we = 1'b1;
    end else if (state == ST_DONE && in_range && f == FUNC_UPD) begin
      days_we = 1'b1;
      days_wd = upd_days;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      cnt       <= '0;
      prev_bits <= '0;
      next_bits <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (clearing) begin
        cnt <= cnt + 1'b1;
        if (cnt == (AW+1)'(NODES - 1)) clearing <= 1'b0;
      end
      case (state)
        ST_IDLE: if (start && !clearing) begin
          f <= func; n <= node; o <= other_node; b <= bit_value;
          idays <= initial_days; u <= random_u;
          cnt <= '0; rd <= (AW+1)'(1); k <= '0;
        end
        ST_READ: begin
          if (f == FUNC_INIT && in_range) prev_bits[n[AW-1:0]] <= b;
        end
        // adj_q holds row cnt; count it when both bits are set
        ST_COUNT: if (cnt != (AW+1)'(NODES)) begin
          if (prev_bits[AW'(cnt)] && adj_q[n[AW-1:0]]) k <= k + 1'b1;
          cnt <= cnt + 1'b1;
          rd  <= rd + 1'b1;
        end
        ST_DONE: begin
          done               <= 1'b1;
          out_node           <= n;
          infected           <= 1'b0;
          days_left          <= 8'd0;
          infected_neighbors <= 7'd0;
          day_vector         <= 64'd0;
          if (f == FUNC_ENDDAY) begin
            prev_bits  <= next_bits;
            next_bits  <= '0;
            out_node   <= 6'd0;
            day_vector <= 64'(next_bits);
          end else if (in_range && f == FUNC_INIT) begin
            infected  <= b;
            days_left <= 8'(init_days);
          end else if (in_range && f == FUNC_UPD) begin
            infected           <= now_inf;
            days_left          <= 8'(upd_days);
            infected_neighbors <= k;
            next_bits[n[AW-1:0]] <= now_inf;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == ST_DONE)
    else $error("strobe without a finished item");
  assert property (@(posedge clk) disable iff (rst) (start && busy) |=> !done || $past(state) == ST_DONE)
    else $error("item taken while busy");
  assert property (@(posedge clk) disable iff (rst) clearing |-> state == ST_IDLE)
    else $error("work during clearing sweep");
endmodule
